// ===== sv/nested_section_profiler_core_macros.svh =====
// Assertion macros used by the profiler checker.
`ifndef NESTED_SECTION_PROFILER_CORE_MACROS_SVH
`define NESTED_SECTION_PROFILER_CORE_MACROS_SVH

// Check cons in the cycle after ante.
`define NSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("profiler check failed");

// Check cons in the same cycle as ante.
`define NSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("profiler check failed");

`endif

// ===== sv/nsp_pkg.sv =====
// Shared types, codes and defaults of the nested section profiler.
package nsp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int RING_LEN_DEF    = 8;
    localparam int TAG_BITS_DEF    = 8;

    localparam logic [1:0] FN_BEGIN = 2'd0;
    localparam logic [1:0] FN_END   = 2'd1;
    localparam logic [1:0] FN_FIND  = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STACK_FULL  = 3'd1;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  tag_id;
        logic [31:0] timestamp;
        logic [7:0]  phase;
        logic [3:0]  slot_sel;
        logic [2:0]  ring_sel;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] duration;
        logic [31:0] calls;
        logic [31:0] total_cycles;
        logic [31:0] min_cycles;
        logic [31:0] max_cycles;
        logic [7:0]  phase_out;
        logic [31:0] drop_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] calls;
        logic [31:0] total_cycles;
        logic [31:0] min_cycles;
        logic [31:0] max_cycles;
    } stat_t;

    typedef struct packed {
        logic cmp_en;
        logic alloc_mode;
        logic alloc_en;
    } dir_ctl_t;

    typedef struct packed {
        logic hit;
        logic fresh;
    } dir_sts_t;

endpackage

// ===== sv/nested_section_profiler_core.sv =====
// Nested section profiler top level: sequencer, section stack and slot statistics.
//
// Usage: events enter on the req channel (valid/ready) as one nsp_pkg::req_t word:
// begin pushes a tag and start time, end pops and charges the duration to a slot,
// find looks a tag up, read returns one slot's statistics and one ring entry.
// Each event yields exactly one nsp_pkg::rsp_t word on the rsp channel.
// Events are handled one at a time. From acceptance to the result word, begin
// and read pass the dispatch state, find the search and, on a hit, statistics
// states, end all three (an end that fails early skips the later ones), then the
// output state; the next event can be accepted once its result is loaded. The
// states follow from the section stack read, the registered slot directory
// search and the read-modify-write of the slot statistics memory.
// A result waits in the output register while rsp_ready is low; the sequencer
// may take and work on the next event meanwhile and holds its result until
// the output register is free.
// Reset clears the stack pointer, the drop counter, the slot used flags and the
// channel state; slot contents are ignored until a slot is allocated, and ring
// entries read as zero until written, so no clearing pass is needed.
module nested_section_profiler_core #(
    parameter int STACK_DEPTH = nsp_pkg::STACK_DEPTH_DEF,
    parameter int SLOT_COUNT  = nsp_pkg::SLOT_COUNT_DEF,
    parameter int RING_LEN    = nsp_pkg::RING_LEN_DEF,
    parameter int TAG_BITS    = nsp_pkg::TAG_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  nsp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output nsp_pkg::rsp_t rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_STAT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int LBL_W      = (TAG_BITS > 8) ? TAG_BITS : 8;
    localparam int MW         = 32 + LBL_W;
    localparam int RING_DEPTH = SLOT_COUNT * RING_LEN;
    localparam int MEM_DEPTH  = RING_DEPTH + STACK_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RP_W       = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int PTR_W      = $clog2(STACK_DEPTH + 1);
    localparam int STAT_W     = $bits(nsp_pkg::stat_t);
    localparam int SW         = STAT_W + RP_W + 1;

    logic [2:0]          state_reg, state_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [31:0]         drops_reg, drops_next;
    logic                rsp_valid_reg, rsp_valid_next;
    nsp_pkg::req_t       req_reg, req_next;
    nsp_pkg::rsp_t       res_reg, res_next;
    nsp_pkg::rsp_t       rsp_reg, rsp_next;
    logic [31:0]         dt_reg, dt_next;
    logic                fresh_reg, fresh_next;
    logic [SLOT_AW-1:0]  slot_reg, slot_next;

    logic                mem_we, mem_re;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [MW-1:0]       mem_wdata, mem_rdata;
    logic                st_we, st_re;
    logic [SLOT_AW-1:0]  st_waddr, st_raddr;
    logic [SW-1:0]       st_wdata, st_rdata;

    nsp_pkg::dir_ctl_t   dctl;
    nsp_pkg::dir_sts_t   dsts;
    logic [TAG_BITS-1:0] cmp_tag;
    logic [SLOT_AW-1:0]  found;
    logic                qry_used;

    nsp_pkg::stat_t      st_stat, old_stat, new_stat;
    logic [RP_W-1:0]     st_pos, old_pos, new_pos;
    logic                st_full, old_full, new_full;
    logic [31:0]         dt_calc;
    logic                in_sel_ok, reg_sel_ok, ring_ok;

    assign st_stat  = nsp_pkg::stat_t'(st_rdata[STAT_W-1:0]);
    assign st_pos   = st_rdata[SW-2 -: RP_W];
    assign st_full  = st_rdata[SW-1];
    assign old_stat = fresh_reg ? '0 : st_stat;
    assign old_pos  = fresh_reg ? '0 : st_pos;
    assign old_full = fresh_reg ? 1'b0 : st_full;
    assign dt_calc  = req_reg.timestamp - mem_rdata[31:0];

    assign in_sel_ok  = (int'(req.slot_sel) < SLOT_COUNT) && (int'(req.ring_sel) < RING_LEN);
    assign reg_sel_ok = (int'(req_reg.slot_sel) < SLOT_COUNT) &&
                        (int'(req_reg.ring_sel) < RING_LEN);
    assign ring_ok    = qry_used && (st_full || (int'(req_reg.ring_sel) < int'(st_pos)));

    nsp_ram #(
        .W     (MW),
        .DEPTH (MEM_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nsp_ram #(
        .W     (SW),
        .DEPTH (SLOT_COUNT)
    ) u_stat_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    nsp_slot_dir #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_BITS   (TAG_BITS)
    ) u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .cmp_tag  (cmp_tag),
        .qry_idx  (SLOT_AW'(req_reg.slot_sel)),
        .qry_used (qry_used),
        .found    (found),
        .sts      (dsts)
    );

    nsp_stat_upd #(
        .RING_LEN (RING_LEN)
    ) u_upd (
        .old_stat (old_stat),
        .old_pos  (old_pos),
        .old_full (old_full),
        .dt       (dt_reg),
        .new_stat (new_stat),
        .new_pos  (new_pos),
        .new_full (new_full)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        drops_next     = drops_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        dt_next        = dt_reg;
        fresh_next     = fresh_reg;
        slot_next      = slot_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        st_re          = 1'b0;
        st_raddr       = '0;
        dctl           = '0;
        cmp_tag        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.func)
                        nsp_pkg::FN_BEGIN:
                        begin
                            state_next = S_DISP;
                        end
                        nsp_pkg::FN_END:
                        begin
                            mem_re     = (ptr_reg != '0);
                            mem_raddr  = MEM_AW'(RING_DEPTH + int'(ptr_reg) - 1);
                            state_next = S_DISP;
                        end
                        nsp_pkg::FN_FIND:
                        begin
                            dctl.cmp_en = 1'b1;
                            cmp_tag     = TAG_BITS'(req.tag_id);
                            state_next  = S_SRCH;
                        end
                        default:
                        begin
                            mem_re     = in_sel_ok;
                            mem_raddr  = MEM_AW'(int'(req.slot_sel) * RING_LEN +
                                                 int'(req.ring_sel));
                            st_re      = in_sel_ok;
                            st_raddr   = SLOT_AW'(req.slot_sel);
                            state_next = S_DISP;
                        end
                    endcase
                end
            end

            S_DISP:
            begin
                res_next   = '0;
                state_next = S_OUT;
                case (req_reg.func)
                    nsp_pkg::FN_BEGIN:
                    begin
                        if (ptr_reg >= PTR_W'(STACK_DEPTH))
                        begin
                            drops_next      = drops_reg + 32'd1;
                            res_next.status = nsp_pkg::ST_STACK_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = MEM_AW'(RING_DEPTH + int'(ptr_reg));
                            mem_wdata = {LBL_W'(TAG_BITS'(req_reg.tag_id)), req_reg.timestamp};
                            ptr_next  = ptr_reg + PTR_W'(1);
                            res_next.status = nsp_pkg::ST_OK;
                        end
                    end
                    nsp_pkg::FN_END:
                    begin
                        if (ptr_reg == '0)
                        begin
                            res_next.status = nsp_pkg::ST_STACK_EMPTY;
                        end
                        else
                        begin
                            ptr_next        = ptr_reg - PTR_W'(1);
                            dt_next         = dt_calc;
                            dctl.cmp_en     = 1'b1;
                            dctl.alloc_mode = 1'b1;
                            cmp_tag         = TAG_BITS'(mem_rdata[MW-1:32]);
                            state_next      = S_SRCH;
                        end
                    end
                    default:
                    begin
                        if (!reg_sel_ok)
                        begin
                            res_next.status = nsp_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            res_next.status = nsp_pkg::ST_OK;
                            res_next.slot   = req_reg.slot_sel;
                            if (qry_used)
                            begin
                                res_next.calls        = st_stat.calls;
                                res_next.total_cycles = st_stat.total_cycles;
                                res_next.min_cycles   = st_stat.min_cycles;
                                res_next.max_cycles   = st_stat.max_cycles;
                            end
                            if (ring_ok)
                            begin
                                res_next.duration  = mem_rdata[31:0];
                                res_next.phase_out = 8'(mem_rdata[MW-1:32]);
                            end
                        end
                    end
                endcase
            end

            S_SRCH:
            begin
                slot_next  = found;
                fresh_next = dsts.fresh;
                if (dsts.hit)
                begin
                    st_re      = 1'b1;
                    st_raddr   = found;
                    dctl.alloc_en = (req_reg.func == nsp_pkg::FN_END) && dsts.fresh;
                    state_next = S_STAT;
                end
                else
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                    if (req_reg.func == nsp_pkg::FN_END)
                    begin
                        drops_next        = drops_reg + 32'd1;
                        res_next.status   = nsp_pkg::ST_TABLE_FULL;
                        res_next.duration = dt_reg;
                    end
                    else
                    begin
                        res_next.status = nsp_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_STAT:
            begin
                res_next        = '0;
                res_next.status = nsp_pkg::ST_OK;
                res_next.slot   = 4'(slot_reg);
                state_next      = S_OUT;
                if (req_reg.func == nsp_pkg::FN_END)
                begin
                    st_we     = 1'b1;
                    st_waddr  = slot_reg;
                    st_wdata  = {new_full, new_pos, new_stat};
                    mem_we    = 1'b1;
                    mem_waddr = MEM_AW'(int'(slot_reg) * RING_LEN + int'(old_pos));
                    mem_wdata = {LBL_W'(req_reg.phase), dt_reg};
                    res_next.duration     = dt_reg;
                    res_next.calls        = new_stat.calls;
                    res_next.total_cycles = new_stat.total_cycles;
                    res_next.min_cycles   = new_stat.min_cycles;
                    res_next.max_cycles   = new_stat.max_cycles;
                    res_next.phase_out    = req_reg.phase;
                end
                else
                begin
                    res_next.calls        = st_stat.calls;
                    res_next.total_cycles = st_stat.total_cycles;
                    res_next.min_cycles   = st_stat.min_cycles;
                    res_next.max_cycles   = st_stat.max_cycles;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next            = res_reg;
                    rsp_next.drop_count = drops_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            drops_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            drops_reg     <= drops_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
        dt_reg    <= dt_next;
        fresh_reg <= fresh_next;
        slot_reg  <= slot_next;
    end

endmodule

// ===== sv/nsp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module nsp_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [W-1:0]                           wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [W-1:0]                           rdata
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nsp_slot_dir.sv =====
// Slot directory: used flags, tags, registered match vector and first-hit encoder.
module nsp_slot_dir #(
    parameter int SLOT_COUNT = nsp_pkg::SLOT_COUNT_DEF,
    parameter int TAG_BITS   = nsp_pkg::TAG_BITS_DEF,
    localparam int SLOT_AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nsp_pkg::dir_ctl_t  ctl,
    input  logic [TAG_BITS-1:0] cmp_tag,
    input  logic [SLOT_AW-1:0] qry_idx,
    output logic               qry_used,
    output logic [SLOT_AW-1:0] found,
    output nsp_pkg::dir_sts_t  sts
);

    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] match_reg;
    logic [TAG_BITS-1:0]   tag_reg [SLOT_COUNT];
    logic [TAG_BITS-1:0]   hold_tag_reg;
    logic [SLOT_COUNT-1:0] low_hit;
    logic [SLOT_AW-1:0]    found_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctl.alloc_en)
        begin
            used_reg[found_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            hold_tag_reg <= cmp_tag;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                match_reg[i] <= used_reg[i] ? (tag_reg[i] == cmp_tag) : ctl.alloc_mode;
            end
        end
        if (ctl.alloc_en)
        begin
            tag_reg[found_idx] <= hold_tag_reg;
        end
    end

    // isolate the lowest set bit, then encode it
    assign low_hit = match_reg & (~match_reg + SLOT_COUNT'(1));

    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (low_hit[i])
            begin
                found_idx = found_idx | SLOT_AW'(i);
            end
        end
    end

    assign found     = found_idx;
    assign sts.hit   = |match_reg;
    assign sts.fresh = !used_reg[found_idx];
    assign qry_used  = used_reg[qry_idx];

endmodule

// ===== sv/nsp_stat_upd.sv =====
// Slot statistics and ring position update for a completed section.
module nsp_stat_upd #(
    parameter int RING_LEN = nsp_pkg::RING_LEN_DEF,
    localparam int RP_W    = (RING_LEN > 1) ? $clog2(RING_LEN) : 1
) (
    input  nsp_pkg::stat_t  old_stat,
    input  logic [RP_W-1:0] old_pos,
    input  logic            old_full,
    input  logic [31:0]     dt,
    output nsp_pkg::stat_t  new_stat,
    output logic [RP_W-1:0] new_pos,
    output logic            new_full
);

    logic [31:0] calls_inc;
    logic [RP_W:0] pos_inc;
    logic        wrap;

    assign calls_inc = old_stat.calls + 32'd1;
    assign pos_inc   = {1'b0, old_pos} + (RP_W + 1)'(1);
    assign wrap      = (pos_inc == (RP_W + 1)'(RING_LEN));

    always_comb
    begin
        new_stat.calls        = calls_inc;
        new_stat.total_cycles = old_stat.total_cycles + dt;
        new_stat.min_cycles   = ((calls_inc == 32'd1) || (dt < old_stat.min_cycles)) ?
                                dt : old_stat.min_cycles;
        new_stat.max_cycles   = (dt > old_stat.max_cycles) ? dt : old_stat.max_cycles;
        new_pos               = wrap ? '0 : pos_inc[RP_W-1:0];
        new_full              = old_full | wrap;
    end

endmodule

// ===== sv/nsp_checker.sv =====
// Port-level checks of the profiler top level and their binding.
`include "nested_section_profiler_core_macros.svh"

module nsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input nsp_pkg::rsp_t rsp
);

    // one event at a time: req_ready stays low after a word is taken
    `NSP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready ##1 !req_ready)
    // a new result is only loaded while the sequencer is busy
    `NSP_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready))
    // hold a stalled result word
    `NSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind nested_section_profiler_core nsp_checker u_nsp_checker (.*);
